// ===== hdl/gcr_pkg.sv =====
// Shared types, glyph table and character mapping for the glyph column text renderer.
package gcr_pkg;

  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_COUNT  = 42;
  localparam int GIDX_W       = 6;
  localparam int COL_W        = 3;
  localparam int QUEUE_DEPTH  = 6;
  localparam int CNT_W        = 3;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_TENTHS = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [GIDX_W-1:0] IDX_BLANK    = 6'd0;
  localparam logic [GIDX_W-1:0] IDX_DIGIT0   = 6'd1;
  localparam logic [GIDX_W-1:0] IDX_LETTER_A = 6'd11;
  localparam logic [GIDX_W-1:0] IDX_COLON    = 6'd37;
  localparam logic [GIDX_W-1:0] IDX_PERCENT  = 6'd38;
  localparam logic [GIDX_W-1:0] IDX_DOT      = 6'd39;
  localparam logic [GIDX_W-1:0] IDX_DASH     = 6'd40;
  localparam logic [GIDX_W-1:0] IDX_SLASH    = 6'd41;

  localparam logic [7:0]       SPACER_COL = 8'h00;
  localparam logic [COL_W-1:0] COL_SPACER = 3'd5;

  // Reciprocal of ten: (n * 52429) >> 19 equals n / 10 for every 16-bit n.
  localparam logic [16:0] RECIP10       = 17'd52429;
  localparam int          RECIP10_SHIFT = 19;

  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E},
    '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46},
    '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10},
    '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30},
    '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36},
    '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36},
    '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
    '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01},
    '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
    '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01},
    '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40},
    '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
    '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06},
    '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46},
    '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01},
    '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
    '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63},
    '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43},
    '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h06,8'h09,8'h09,8'h06},
    '{8'h00,8'h00,8'h08,8'h00,8'h00},
    '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h20,8'h10,8'h08,8'h04,8'h02}
  };

  typedef struct packed {
    logic             load_char;
    logic             load_num;
    logic             step;
    logic             push_dot;
    logic             emit;
    logic             emit_last;
    logic [COL_W-1:0] col;
  } gcr_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic one_left;
  } gcr_stat_t;

  function automatic logic [GIDX_W-1:0] glyph_of(input logic [7:0] ch);
    logic [7:0] d;
    logic [GIDX_W-1:0] g;
    g = IDX_BLANK;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      g = IDX_DIGIT0 + d[GIDX_W-1:0];
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
      g = IDX_LETTER_A + d[GIDX_W-1:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61;
      g = IDX_LETTER_A + d[GIDX_W-1:0];
    end else if (ch == 8'h3A) begin
      g = IDX_COLON;
    end else if (ch == 8'h25) begin
      g = IDX_PERCENT;
    end else if (ch == 8'h2E) begin
      g = IDX_DOT;
    end else if (ch == 8'h2D) begin
      g = IDX_DASH;
    end else if (ch == 8'h2F) begin
      g = IDX_SLASH;
    end
    return g;
  endfunction

  function automatic logic [7:0] glyph_column(input logic [GIDX_W-1:0] idx,
                                              input logic [COL_W-1:0] col);
    logic [7:0] b;
    b = SPACER_COL;
    if (int'(idx) < GLYPH_COUNT && int'(col) < GLYPH_COLS) begin
      b = GLYPH_ROM[idx][col];
    end
    return b;
  endfunction

endpackage

// ===== hdl/gcr_ctrl.sv =====
// Sequencer for the renderer: digit conversion steps and column emission.
module gcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_kind,
  input  gcr_pkg::gcr_stat_t stat,
  output gcr_pkg::gcr_cmd_t  cmd,
  output logic              busy
);
  import gcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRAC,
    S_DOT,
    S_CONV,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    cmd           = '0;
    cmd.col       = col_r;
    case (state_r)
      S_IDLE: begin
        col_nxt = '0;
        if (accept) begin
          case (in_kind)
            KIND_CHAR: begin
              cmd.load_char = 1'b1;
              state_nxt     = S_EMIT;
            end
            KIND_NUMBER: begin
              cmd.load_num = 1'b1;
              state_nxt    = S_CONV;
            end
            KIND_TENTHS: begin
              cmd.load_num = 1'b1;
              state_nxt    = S_FRAC;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FRAC: begin
        cmd.step  = 1'b1;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.push_dot = 1'b1;
        state_nxt    = S_CONV;
      end
      S_CONV: begin
        // One decimal digit per cycle until the quotient runs out.
        cmd.step = 1'b1;
        if (stat.q_zero) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (col_r == COL_SPACER) begin
          col_nxt = '0;
          if (stat.one_left) begin
            cmd.emit_last = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// ===== hdl/gcr_dpath.sv =====
// Datapath: divide-by-ten step, glyph index queue and registered column output.
module gcr_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       in_value,
  input  gcr_pkg::gcr_cmd_t  cmd,
  output gcr_pkg::gcr_stat_t stat,
  output logic [7:0]        out_column_byte,
  output logic              out_last,
  output logic              out_valid
);
  import gcr_pkg::*;

  logic [15:0]       n_r;
  logic [32:0]       prod;
  logic [12:0]       quot;
  logic [15:0]       quot_x10;
  logic [15:0]       rem_full;
  logic [GIDX_W-1:0] digit_g;
  logic [GIDX_W-1:0] q_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic              push;
  logic [GIDX_W-1:0] push_g;
  logic              pop;
  logic [7:0]        out_column_byte_r;
  logic              out_last_r;
  logic              out_valid_r;

  assign prod     = {1'b0, n_r} * {16'd0, RECIP10};
  assign quot     = prod[RECIP10_SHIFT +: 13];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = n_r - quot_x10;
  assign digit_g  = IDX_DIGIT0 + {2'b00, rem_full[3:0]};

  assign stat.q_zero   = (quot == '0);
  assign stat.one_left = (cnt_r == CNT_W'(1));

  // Characters are pushed in reverse print order, so the front is printed first.
  always_comb begin
    push   = cmd.load_char || cmd.step || cmd.push_dot;
    push_g = digit_g;
    if (cmd.load_char)     push_g = glyph_of(in_value[7:0]);
    else if (cmd.push_dot) push_g = IDX_DOT;
  end

  assign pop = cmd.emit && (cmd.col == COL_SPACER);

  always_ff @(posedge clk) begin
    if (cmd.load_num) n_r <= in_value;
    else if (cmd.step) n_r <= {3'b000, quot};

    if (push) begin
      q_r[0] <= push_g;
      for (int i = 1; i < QUEUE_DEPTH; i++) q_r[i] <= q_r[i-1];
    end else if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_r[i] <= q_r[i+1];
      q_r[QUEUE_DEPTH-1] <= IDX_BLANK;
    end

    out_column_byte_r <= (cmd.col == COL_SPACER) ? SPACER_COL
                                                 : glyph_column(q_r[0], cmd.col);
    out_last_r        <= cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_char)     cnt_r <= CNT_W'(1);
      else if (cmd.load_num) cnt_r <= '0;
      else if (push)         cnt_r <= cnt_r + 1'b1;
      else if (pop)          cnt_r <= cnt_r - 1'b1;
      out_valid_r <= cmd.emit;
    end
  end

  assign out_column_byte = out_column_byte_r;
  assign out_last        = out_last_r;
  assign out_valid       = out_valid_r;

endmodule

// ===== hdl/glyph_column_text_renderer_top.sv =====
// Top level of the glyph column text renderer: controller plus datapath.
//
// An item (in_kind, in_value) is taken at a clock edge where start is high and
// busy is low. Kind 0 prints the character in in_value[7:0], kind 1 prints
// in_value as an unsigned decimal without leading zeros, kind 2 prints it as
// tenths with one decimal, and kind 3 is dropped without any output.
// Every printed character yields six column words on out_column_byte: five
// glyph columns and one blank column. out_valid marks each word for exactly
// one cycle; out_last flags the final word of the item. Words of one item
// come in consecutive cycles and cannot be held off by the receiver.
// A number first passes the divide-by-ten step, which yields its decimal
// digits (for kind 2 first the fraction digit, then the decimal point),
// then every character is emitted as its column words. For kind 0 the
// sequencer goes from idle straight to emission, and out_valid is registered.
// busy falls in the cycle that shows the last word, so the next item may be
// started then. A synchronous reset clears the sequencer and out_valid.
module glyph_column_text_renderer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_value,
  output logic [7:0]  out_column_byte,
  output logic        out_last,
  output logic        out_valid
);
  import gcr_pkg::*;

  gcr_cmd_t  cmd;
  gcr_stat_t stat;

  gcr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  gcr_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_column_byte (out_column_byte),
    .out_last        (out_last),
    .out_valid       (out_valid)
  );

endmodule

// ===== hdl/gcr_checker.sv =====
// Port-level checks of the renderer and their binding to the top level.
module gcr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_last,
  input logic       out_valid
);
  import gcr_pkg::*;

  // Words of one item leave in consecutive cycles.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside an output burst");

  // The last word is never followed directly by another word.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("word right after the last word");

  // A printable item makes the block busy.
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind != KIND_NONE) |=> busy)
    else $error("busy not raised after start");

  // While idle, only the closing word of the previous item may show.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && out_valid |-> out_last)
    else $error("word shown while idle");

  // A dropped kind does not start any work.
  a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == KIND_NONE) |=> !busy)
    else $error("unused kind started work");

endmodule

bind glyph_column_text_renderer_top gcr_checker u_gcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_last  (out_last),
  .out_valid (out_valid)
);
